@@ sv/rtp_pkg.sv @@
// Shared types, character codes and note tables for the ringtone text parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rtp_pkg;

  localparam int CharW  = 8;
  localparam int WntW   = 24;
  localparam int TimeW  = 25;
  localparam int FreqW  = 14;
  localparam int LenW   = 8;
  localparam int OctW   = 4;
  localparam int KindW  = 2;
  localparam int IdxW   = 3;
  localparam int SetW   = 12;
  localparam int DivCntW = 5;
  localparam int DivSteps = WntW;

  localparam logic [KindW-1:0] KIND_TITLE = 2'd0;
  localparam logic [KindW-1:0] KIND_NOTE  = 2'd1;
  localparam logic [KindW-1:0] KIND_END   = 2'd2;

  localparam logic [1:0] SET_OTHER = 2'd0;
  localparam logic [1:0] SET_OCT   = 2'd1;
  localparam logic [1:0] SET_DUR   = 2'd2;
  localparam logic [1:0] SET_BPM   = 2'd3;

  localparam logic [CharW-1:0] CH_NUL   = 8'h00;
  localparam logic [CharW-1:0] CH_HASH  = 8'h23;
  localparam logic [CharW-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
  localparam logic [CharW-1:0] CH_DIG0  = 8'h30;
  localparam logic [CharW-1:0] CH_DIG9  = 8'h39;
  localparam logic [CharW-1:0] CH_COLON = 8'h3A;
  localparam logic [CharW-1:0] CH_LA    = 8'h61;
  localparam logic [CharW-1:0] CH_LB    = 8'h62;
  localparam logic [CharW-1:0] CH_LD    = 8'h64;
  localparam logic [CharW-1:0] CH_LG    = 8'h67;
  localparam logic [CharW-1:0] CH_LO    = 8'h6F;
  localparam logic [CharW-1:0] CH_LZ    = 8'h7A;

  localparam logic [LenW-1:0] DEF_LENGTH = 8'd4;
  localparam logic [OctW-1:0] DEF_OCT    = 4'd6;
  localparam logic [OctW-1:0] OCT_MAX    = 4'd9;
  localparam logic [OctW-1:0] OCT_BASE   = 4'd5;
  localparam logic [LenW-1:0] SET_SAT    = 8'd255;
  localparam logic [WntW-1:0] WNT_RESET  = 24'd2000000;

  localparam int SHARP_NUM = 10595;
  localparam int SHARP_DEN = 10000;

  localparam logic [FreqW-1:0] TONE_HZ [7] = '{
    14'd440, 14'd494, 14'd523, 14'd587, 14'd659, 14'd698, 14'd784
  };

  localparam logic [FreqW-1:0] SHARP_HZ [7] = '{
    14'((SHARP_NUM * 440) / SHARP_DEN), 14'((SHARP_NUM * 494) / SHARP_DEN),
    14'((SHARP_NUM * 523) / SHARP_DEN), 14'((SHARP_NUM * 587) / SHARP_DEN),
    14'((SHARP_NUM * 659) / SHARP_DEN), 14'((SHARP_NUM * 698) / SHARP_DEN),
    14'((SHARP_NUM * 784) / SHARP_DEN)
  };

  // idx 0 is "no tone", 1..7 are a..g
  function automatic logic [FreqW-1:0] note_hz(input logic [IdxW-1:0] idx,
                                               input logic sharp);
    logic [IdxW-1:0] k;
    k = idx - 3'd1;
    if (idx == 3'd0) begin
      return '0;
    end else if (sharp) begin
      return SHARP_HZ[k];
    end else begin
      return TONE_HZ[k];
    end
  endfunction

  typedef struct packed {
    logic zero;
    logic digit;
    logic lower;
    logic colon;
    logic comma;
    logic hash;
    logic dot;
    logic div_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic title_out;
    logic end_out;
    logic note_out;
    logic song_rst;
    logic start_note;
    logic set_letter;
    logic acc_setting;
    logic commit_def;
    logic dur1;
    logic dur2;
    logic letter;
    logic sharp;
    logic dot;
    logic oct;
    logic emit;
  } cmd_t;

endpackage

@@ sv/ringtone_text_note_parser.sv @@
// Timing: a title byte or end-of-song result is in the output register in the cycle after
// its transfer; a note is loaded when the 24-step restoring divide started by its closing byte is done.
// Throughput: one text byte per cycle while the output register is free; input is blocked while a note divides.
// Reset (rst_ni, async low): title phase, default length 4, default octave 6,
// whole_note_time 2000000, output empty. No clearing pass.
`timescale 1ns / 1ps
module ringtone_text_note_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] title_byte, [32:8] note_time,
                                      // [46:33] note_freq, [47] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // song_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtp_pkg::*;

  logic [WntW-1:0]  wnt_q, wnt_d;
  stat_t            stat;
  cmd_t             cmd;
  logic [CharW-1:0] title_byte;
  logic [TimeW-1:0] note_time;
  logic [FreqW-1:0] note_freq;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == 1'b0;
  assign prdata  = reg_sel ? {8'd0, wnt_q} : 32'd0;

  always_comb begin
    wnt_d = wnt_q;
    if (psel && penable && pwrite && reg_sel) begin
      wnt_d = pwdata[WntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wnt_q <= WNT_RESET;
    end else begin
      wnt_q <= wnt_d;
    end
  end

  rtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rtp_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (s_axis_tdata),
    .wnt_i        (wnt_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .kind_o       (m_axis_tuser),
    .title_byte_o (title_byte),
    .note_time_o  (note_time),
    .note_freq_o  (note_freq),
    .song_end_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, note_freq, note_time, title_byte};

endmodule

@@ sv/rtp_div.sv @@
// Restoring divider, one quotient bit per cycle: whole-note time by note length.
// Depends on rtp_pkg.
`timescale 1ns / 1ps
module rtp_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rtp_pkg::WntW-1:0] dividend_i,
  input  logic [rtp_pkg::LenW-1:0] divisor_i,
  output logic                     done_o,
  output logic [rtp_pkg::WntW-1:0] quo_o
);
  import rtp_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [WntW-1:0]    quo_q, quo_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [LenW-1:0]    dvs_q, dvs_d;
  logic [LenW:0]      trial;
  logic               busy;

  assign busy  = cnt_q != '0;
  assign trial = {rem_q, quo_q[WntW-1]};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = busy && (cnt_q == DivCntW'(1));
    if (start_i) begin
      cnt_d = DivCntW'(DivSteps);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (busy) begin
      cnt_d = cnt_q - DivCntW'(1);
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = LenW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[WntW-2:0], 1'b1};
      end else begin
        rem_d = trial[LenW-1:0];
        quo_d = {quo_q[WntW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ sv/rtp_dpath.sv @@
// Datapath: character decode, song defaults, current note, divider, output register.
// Depends on rtp_pkg and rtp_div; driven by rtp_ctrl commands.
`timescale 1ns / 1ps
module rtp_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rtp_pkg::CharW-1:0] char_i,
  input  logic [rtp_pkg::WntW-1:0]  wnt_i,
  input  rtp_pkg::cmd_t             cmd_i,
  output rtp_pkg::stat_t            stat_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [rtp_pkg::KindW-1:0] kind_o,
  output logic [rtp_pkg::CharW-1:0] title_byte_o,
  output logic [rtp_pkg::TimeW-1:0] note_time_o,
  output logic [rtp_pkg::FreqW-1:0] note_freq_o,
  output logic                      song_end_o
);
  import rtp_pkg::*;

  logic [LenW-1:0] def_len_q, def_len_d;
  logic [OctW-1:0] def_oct_q, def_oct_d;
  logic [1:0]      set_let_q, set_let_d;
  logic [LenW-1:0] set_val_q, set_val_d;
  logic [LenW-1:0] cur_len_q, cur_len_d;
  logic [OctW-1:0] cur_oct_q, cur_oct_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            sharp_q, sharp_d;
  logic            dot_q, dot_d;

  logic [FreqW-1:0] pfreq_q;
  logic             pdot_q, pzero_q, pend_q;

  logic             ovalid_q, ovalid_d;
  logic [KindW-1:0] kind_q;
  logic [CharW-1:0] title_q;
  logic [TimeW-1:0] time_q;
  logic [FreqW-1:0] freq_q;
  logic             end_q;

  logic [3:0]       dig;
  logic [SetW-1:0]  set_acc;
  logic [SetW-1:0]  len_acc;
  logic [FreqW-1:0] base_hz;
  logic [OctW-1:0]  shamt;
  logic [FreqW-1:0] oct_hz;
  logic             div_done;
  logic [WntW-1:0]  quo;
  logic [TimeW-1:0] t_raw;
  logic [TimeW-1:0] t_fin;

  assign dig = char_i[3:0];

  always_comb begin
    stat_o.zero     = char_i == CH_NUL;
    stat_o.digit    = (char_i >= CH_DIG0) && (char_i <= CH_DIG9);
    stat_o.lower    = (char_i >= CH_LA) && (char_i <= CH_LZ);
    stat_o.colon    = char_i == CH_COLON;
    stat_o.comma    = char_i == CH_COMMA;
    stat_o.hash     = char_i == CH_HASH;
    stat_o.dot      = char_i == CH_DOT;
    stat_o.div_done = div_done;
    stat_o.out_free = !ovalid_q || out_ready_i;
  end

  assign set_acc = SetW'(set_val_q) * SetW'(10) + SetW'(dig);
  assign len_acc = SetW'(cur_len_q) * SetW'(10) + SetW'(dig);

  always_comb begin
    def_len_d = def_len_q;
    def_oct_d = def_oct_q;
    set_let_d = set_let_q;
    set_val_d = set_val_q;
    cur_len_d = cur_len_q;
    cur_oct_d = cur_oct_q;
    idx_d     = idx_q;
    sharp_d   = sharp_q;
    dot_d     = dot_q;
    if (cmd_i.set_letter) begin
      set_val_d = '0;
      priority if (char_i == CH_LO) begin
        set_let_d = SET_OCT;
      end else if (char_i == CH_LD) begin
        set_let_d = SET_DUR;
      end else if (char_i == CH_LB) begin
        set_let_d = SET_BPM;
      end else begin
        set_let_d = SET_OTHER;
      end
    end
    if (cmd_i.acc_setting) begin
      set_val_d = (set_acc > SetW'(SET_SAT)) ? SET_SAT : set_acc[LenW-1:0];
    end
    if (cmd_i.commit_def) begin
      if (set_let_q == SET_OCT) begin
        def_oct_d = (set_val_q > LenW'(OCT_MAX)) ? OCT_MAX : set_val_q[OctW-1:0];
      end else if (set_let_q == SET_DUR) begin
        def_len_d = set_val_q;
      end
    end
    if (cmd_i.dur1) begin
      cur_len_d = LenW'(dig);
    end
    if (cmd_i.dur2) begin
      cur_len_d = len_acc[LenW-1:0];
    end
    if (cmd_i.letter) begin
      idx_d = (char_i <= CH_LG) ? char_i[IdxW-1:0] : '0;
    end
    if (cmd_i.sharp) begin
      sharp_d = 1'b1;
    end
    if (cmd_i.dot) begin
      dot_d = 1'b1;
    end
    if (cmd_i.oct) begin
      cur_oct_d = dig;
    end
    // start_note reads the defaults as just committed
    if (cmd_i.start_note) begin
      cur_len_d = def_len_d;
      cur_oct_d = def_oct_d;
      idx_d     = '0;
      sharp_d   = 1'b0;
      dot_d     = 1'b0;
    end
    if (cmd_i.song_rst) begin
      def_len_d = DEF_LENGTH;
      def_oct_d = DEF_OCT;
      set_let_d = SET_OTHER;
      set_val_d = '0;
      cur_len_d = '0;
      cur_oct_d = '0;
      idx_d     = '0;
      sharp_d   = 1'b0;
      dot_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_len_q <= DEF_LENGTH;
      def_oct_q <= DEF_OCT;
      set_let_q <= SET_OTHER;
      set_val_q <= '0;
      cur_len_q <= '0;
      cur_oct_q <= '0;
      idx_q     <= '0;
      sharp_q   <= 1'b0;
      dot_q     <= 1'b0;
    end else begin
      def_len_q <= def_len_d;
      def_oct_q <= def_oct_d;
      set_let_q <= set_let_d;
      set_val_q <= set_val_d;
      cur_len_q <= cur_len_d;
      cur_oct_q <= cur_oct_d;
      idx_q     <= idx_d;
      sharp_q   <= sharp_d;
      dot_q     <= dot_d;
    end
  end

  // octave doubling, 14-bit wrap
  assign base_hz = note_hz(idx_q, sharp_q);
  assign shamt   = (cur_oct_q > OCT_BASE) ? (cur_oct_q - OCT_BASE) : '0;
  assign oct_hz  = FreqW'(base_hz << shamt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pfreq_q <= oct_hz;
      pdot_q  <= dot_q;
      pzero_q <= cur_len_q == '0;
      pend_q  <= stat_o.zero;
    end
  end

  rtp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.emit),
    .dividend_i (wnt_i),
    .divisor_i  (cur_len_q),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  assign t_raw = pzero_q ? '0 : TimeW'(quo);
  assign t_fin = pdot_q ? (t_raw + (t_raw >> 1)) : t_raw;

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (cmd_i.title_out || cmd_i.end_out || cmd_i.note_out) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.title_out) begin
      kind_q  <= KIND_TITLE;
      title_q <= char_i;
      time_q  <= '0;
      freq_q  <= '0;
      end_q   <= 1'b0;
    end else if (cmd_i.end_out) begin
      kind_q  <= KIND_END;
      title_q <= '0;
      time_q  <= '0;
      freq_q  <= '0;
      end_q   <= 1'b1;
    end else if (cmd_i.note_out) begin
      kind_q  <= KIND_NOTE;
      title_q <= '0;
      time_q  <= t_fin;
      freq_q  <= pfreq_q;
      end_q   <= pend_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign kind_o       = kind_q;
  assign title_byte_o = title_q;
  assign note_time_o  = time_q;
  assign note_freq_o  = freq_q;
  assign song_end_o   = end_q;

endmodule

@@ sv/rtp_ctrl.sv @@
// Parse-phase controller: walks title, defaults and note fields, sequences the divide.
// Depends on rtp_pkg; commands the rtp_dpath datapath.
`timescale 1ns / 1ps
module rtp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rtp_pkg::stat_t stat_i,
  output rtp_pkg::cmd_t  cmd_o
);
  import rtp_pkg::*;

  localparam logic [3:0] PH_TITLE  = 4'd0;
  localparam logic [3:0] PH_DEFS   = 4'd1;
  localparam logic [3:0] PH_DEFVAL = 4'd2;
  localparam logic [3:0] PH_DUR1   = 4'd4;
  localparam logic [3:0] PH_DUR2   = 4'd5;
  localparam logic [3:0] PH_LETTER = 4'd6;
  localparam logic [3:0] PH_SHARP  = 4'd7;
  localparam logic [3:0] PH_DOT    = 4'd8;
  localparam logic [3:0] PH_OCT    = 4'd9;
  localparam logic [3:0] PH_END    = 4'd10;
  localparam logic [3:0] PH_DIV    = 4'd11;

  logic [3:0] phase_q, phase_d;
  logic       last_q, last_d;
  logic       acc;
  logic       in_dur1, in_dur2, in_let, in_sharp, in_dot, in_oct, in_end;

  assign in_ready_o = (phase_q != PH_DIV) && stat_i.out_free;
  assign acc        = in_valid_i && in_ready_o;

  // note fields are optional: a byte that misses one is tried on the next
  assign in_dur1  = phase_q == PH_DUR1;
  assign in_dur2  = (phase_q == PH_DUR2) || (in_dur1 && !stat_i.digit);
  assign in_let   = (phase_q == PH_LETTER) || (in_dur2 && !stat_i.digit);
  assign in_sharp = phase_q == PH_SHARP;
  assign in_dot   = (phase_q == PH_DOT) || (in_sharp && !stat_i.hash);
  assign in_oct   = (phase_q == PH_OCT) || (in_dot && !stat_i.dot);
  assign in_end   = (phase_q == PH_END) || (in_oct && !stat_i.digit);

  always_comb begin
    cmd_o   = '0;
    phase_d = phase_q;
    last_d  = last_q;
    if (phase_q == PH_DIV) begin
      if (stat_i.div_done) begin
        cmd_o.note_out = 1'b1;
        phase_d        = last_q ? PH_TITLE : PH_DUR1;
      end
    end else if (acc) begin
      if (phase_q == PH_DEFS) begin
        if (stat_i.zero) begin
          cmd_o.end_out  = 1'b1;
          cmd_o.song_rst = 1'b1;
          phase_d        = PH_TITLE;
        end else if (stat_i.colon) begin
          cmd_o.start_note = 1'b1;
          phase_d          = PH_DUR1;
        end else if (stat_i.lower) begin
          cmd_o.set_letter = 1'b1;
          phase_d          = PH_DEFVAL;
        end
      end else if (phase_q == PH_DEFVAL) begin
        if (stat_i.zero) begin
          cmd_o.end_out  = 1'b1;
          cmd_o.song_rst = 1'b1;
          phase_d        = PH_TITLE;
        end else if (stat_i.digit) begin
          cmd_o.acc_setting = 1'b1;
        end else if (stat_i.colon) begin
          cmd_o.commit_def = 1'b1;
          cmd_o.start_note = 1'b1;
          phase_d          = PH_DUR1;
        end else if (stat_i.comma) begin
          cmd_o.commit_def = 1'b1;
          phase_d          = PH_DEFS;
        end
      end else if (in_dur1 || in_dur2 || in_let) begin
        if (stat_i.zero) begin
          cmd_o.end_out  = 1'b1;
          cmd_o.song_rst = 1'b1;
          phase_d        = PH_TITLE;
        end else if (in_dur1 && stat_i.digit) begin
          cmd_o.dur1 = 1'b1;
          phase_d    = PH_DUR2;
        end else if (phase_q == PH_DUR2 && stat_i.digit) begin
          cmd_o.dur2 = 1'b1;
          phase_d    = PH_LETTER;
        end else begin
          cmd_o.letter = stat_i.lower;
          phase_d      = PH_SHARP;
        end
      end else if (in_sharp || in_dot || in_oct || in_end) begin
        if (in_sharp && stat_i.hash) begin
          cmd_o.sharp = 1'b1;
          phase_d     = PH_DOT;
        end else if (in_dot && stat_i.dot) begin
          cmd_o.dot = 1'b1;
          phase_d   = PH_OCT;
        end else if (in_oct && stat_i.digit) begin
          cmd_o.oct = 1'b1;
          phase_d   = PH_END;
        end else if (stat_i.comma || stat_i.zero) begin
          cmd_o.emit       = 1'b1;
          cmd_o.song_rst   = stat_i.zero;
          cmd_o.start_note = !stat_i.zero;
          last_d           = stat_i.zero;
          phase_d          = PH_DIV;
        end
      end else begin
        if (stat_i.zero) begin
          cmd_o.end_out  = 1'b1;
          cmd_o.song_rst = 1'b1;
          phase_d        = PH_TITLE;
        end else begin
          cmd_o.title_out = 1'b1;
          phase_d         = stat_i.colon ? PH_DEFS : PH_TITLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TITLE;
      last_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      last_q  <= last_d;
    end
  end

  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIV) |-> !in_ready_o)
    else $error("input taken during divide");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> (phase_q == PH_DIV))
    else $error("divider finished outside divide phase");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.title_out || cmd_o.end_out || cmd_o.note_out) |-> stat_i.out_free)
    else $error("result loaded over a pending one");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.title_out, cmd_o.end_out, cmd_o.note_out, cmd_o.emit}))
    else $error("more than one result action in a cycle");

  a_emit_enters_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (phase_q == PH_DIV))
    else $error("note emit did not start the divide");

endmodule

@@ verif/testbench.sv @@
// Testbench for ringtone_text_note_parser: a table of directed text bytes, then random songs,
// with every output checked against the table's expected result or an in-bench parser model.
// Needs rtp_pkg and the parser RTL; APB register checks included.
`timescale 1ns / 1ps
module testbench;
  import rtp_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] WNT_ADDR = 3'd0;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] PITCHES [8] = '{"a", "b", "c", "d", "e", "f", "g", "p"};

  typedef enum logic [3:0] {
    P_TITLE, P_DEFS, P_DEFVAL, P_LEN1, P_LEN2, P_PITCH, P_SHARP, P_DOT, P_OCT, P_CLOSE
  } parse_phase_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       title;
    logic [TimeW-1:0] note_time;
    logic [FreqW-1:0] freq;
    logic             last;
  } parse_res_t;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    parse_res_t want;
  } dir_row_t;

  localparam parse_res_t END_OUT = '{KIND_END, 8'h00, 25'd0, 14'd0, 1'b1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ringtone_text_note_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // parser model state
  parse_phase_e     phase;
  logic [WntW-1:0]  whole_note;
  logic [LenW-1:0]  def_len;
  logic [OctW-1:0]  def_oct;
  logic [1:0]       set_key;
  logic [LenW-1:0]  set_acc;
  logic [LenW-1:0]  len;
  logic [OctW-1:0]  oct;
  logic [FreqW-1:0] freq;
  logic             dot_on;

  parse_res_t due_outputs [$];
  int err_cnt = 0;
  int bytes_sent = 0;
  int settings_used = 0;
  int titles_seen = 0;
  int notes_seen = 0;
  int ends_seen = 0;
  int quiet_cycles = 0;
  int cyc = 0;

  dir_row_t dir_tbl [28] = '{
    '{8'h00, 1'b1, END_OUT},
    '{"T",   1'b1, '{KIND_TITLE, 8'h54, 25'd0, 14'd0, 1'b0}},
    '{8'hFF, 1'b1, '{KIND_TITLE, 8'hFF, 25'd0, 14'd0, 1'b0}},
    '{":",   1'b1, '{KIND_TITLE, 8'h3A, 25'd0, 14'd0, 1'b0}},
    '{"d", 1'b0, '0}, '{"9", 1'b0, '0}, '{"9", 1'b0, '0}, '{"9", 1'b0, '0},
    '{",", 1'b0, '0}, '{"o", 1'b0, '0}, '{"1", 1'b0, '0}, '{"2", 1'b0, '0},
    '{",", 1'b0, '0}, '{"x", 1'b0, '0}, '{":", 1'b0, '0},
    '{"p", 1'b0, '0}, '{",", 1'b0, '0},
    '{"0", 1'b0, '0}, '{"c", 1'b0, '0}, '{"#", 1'b0, '0}, '{".", 1'b0, '0},
    '{"7", 1'b0, '0}, '{",", 1'b0, '0},
    '{"z", 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{":",   1'b1, '{KIND_TITLE, 8'h3A, 25'd0, 14'd0, 1'b0}},
    '{"b", 1'b0, '0},
    '{8'h00, 1'b1, END_OUT}
  };

  function automatic void note_err(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void song_restart();
    phase = P_TITLE;
    def_len = DEF_LENGTH;
    def_oct = DEF_OCT;
    set_key = SET_OTHER;
    set_acc = '0;
    len = '0;
    oct = '0;
    freq = '0;
    dot_on = 1'b0;
  endfunction

  function automatic void note_restart();
    len = def_len;
    oct = def_oct;
    freq = '0;
    dot_on = 1'b0;
    phase = P_LEN1;
  endfunction

  function automatic parse_res_t note_result();
    parse_res_t r;
    logic [FreqW-1:0] f;
    logic [TimeW-1:0] t;
    logic [OctW-1:0] o;
    r = '0;
    f = freq;
    t = '0;
    for (o = oct; o > OCT_BASE; o--) f = f << 1;
    if (len != 0) t = whole_note / len;
    if (dot_on) t = (3 * t) / 2;
    r.kind = KIND_NOTE;
    r.note_time = t;
    r.freq = f;
    return r;
  endfunction

  // returns 1 when the byte produces an output
  function automatic bit parse_char(input logic [7:0] c, output parse_res_t r);
    bit digit, lower;
    int acc;
    logic [3:0] dval;
    digit = (c >= CH_DIG0) && (c <= CH_DIG9);
    lower = (c >= CH_LA) && (c <= CH_LZ);
    dval = 4'(c - CH_DIG0);
    r = '0;
    if (c == CH_NUL) begin
      if (phase inside {P_SHARP, P_DOT, P_OCT, P_CLOSE}) r = note_result();
      else r.kind = KIND_END;
      r.last = 1'b1;
      song_restart();
      return 1'b1;
    end
    case (phase)
      P_TITLE: begin
        r.kind = KIND_TITLE;
        r.title = c;
        if (c == CH_COLON) phase = P_DEFS;
        return 1'b1;
      end
      P_DEFS: begin
        if (c == CH_COLON) begin
          note_restart();
        end else if (lower) begin
          set_key = (c == CH_LO) ? SET_OCT : (c == CH_LD) ? SET_DUR :
                    (c == CH_LB) ? SET_BPM : SET_OTHER;
          set_acc = '0;
          phase = P_DEFVAL;
        end
        return 1'b0;
      end
      P_DEFVAL: begin
        if (digit) begin
          acc = set_acc * 10 + dval;
          set_acc = (acc > SET_SAT) ? SET_SAT : 8'(acc);
        end else if (c == CH_COLON || c == CH_COMMA) begin
          if (set_key == SET_OCT) def_oct = (set_acc > OCT_MAX) ? OCT_MAX : set_acc[3:0];
          else if (set_key == SET_DUR) def_len = set_acc;
          if (c == CH_COLON) note_restart();
          else phase = P_DEFS;
        end
        return 1'b0;
      end
      default: ;
    endcase
    // note parts are optional: a byte that misses one part is tried on the next
    if (phase == P_LEN1 && digit) begin
      len = 8'(dval);
      phase = P_LEN2;
      return 1'b0;
    end
    if (phase == P_LEN2 && digit) begin
      len = 8'(len * 10 + dval);
      phase = P_PITCH;
      return 1'b0;
    end
    if (phase inside {P_LEN1, P_LEN2, P_PITCH}) begin
      if (lower) freq = (c <= CH_LG) ? TONE_HZ[c - CH_LA] : '0;
      phase = P_SHARP;
      return 1'b0;
    end
    if (phase == P_SHARP && c == CH_HASH) begin
      freq = 14'((SHARP_NUM * freq) / SHARP_DEN);
      phase = P_DOT;
      return 1'b0;
    end
    if (phase inside {P_SHARP, P_DOT} && c == CH_DOT) begin
      dot_on = 1'b1;
      phase = P_OCT;
      return 1'b0;
    end
    if (phase inside {P_SHARP, P_DOT, P_OCT} && digit) begin
      oct = dval;
      phase = P_CLOSE;
      return 1'b0;
    end
    if (c == CH_COMMA) begin
      r = note_result();
      note_restart();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input parse_res_t fixed = '0);
    logic ok;
    bit produced;
    parse_res_t r;
    while (!(bytes_sent inside {[500:699]}) && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    bytes_sent++;
    produced = parse_char(c, r);
    if (typed) due_outputs = {due_outputs, fixed};
    else if (produced) due_outputs = {due_outputs, r};
  endtask

  task automatic send_num(input int v);
    if (v >= 100) send_char(8'(CH_DIG0 + v / 100));
    if (v >= 10) send_char(8'(CH_DIG0 + (v / 10) % 10));
    send_char(8'(CH_DIG0 + v % 10));
  endtask

  task automatic write_song();
    int n, i, v, pick;
    logic [7:0] c;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 10)) send_char(8'($urandom_range(0, 255)));
      if ($urandom_range(99) < 70) send_char(CH_NUL);
      return;
    end
    repeat ($urandom_range(0, 5)) begin
      c = 8'($urandom_range(1, 255));
      send_char((c == CH_COLON) ? CH_UNDER : c);
    end
    send_char(CH_COLON);
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 3);
      c = (pick == 0) ? CH_LD : (pick == 1) ? CH_LO : (pick == 2) ? CH_LB :
          8'($urandom_range(CH_LA, CH_LZ));
      send_char(c);
      if ($urandom_range(99) < 80) send_char(CH_EQUAL);
      v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) : (1 << $urandom_range(0, 5));
      if (c == CH_LO && $urandom_range(0, 1)) v = $urandom_range(4, 7);
      send_num(v);
      if ($urandom_range(99) < 3) begin
        send_char(CH_NUL);
        return;
      end
      send_char((i == n - 1) ? CH_COLON : CH_COMMA);
    end
    if (n == 0) send_char(CH_COLON);
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick >= 4 && pick <= 7) begin
        send_num(1 << $urandom_range(0, 5));
      end else if (pick == 8) begin
        send_char(8'(CH_DIG0 + $urandom_range(0, 9)));
        send_char(8'(CH_DIG0 + $urandom_range(0, 9)));
      end else if (pick == 9) begin
        send_char(8'(CH_DIG0 + $urandom_range(0, 9)));
      end
      pick = $urandom_range(99);
      if (pick < 85) c = PITCHES[$urandom_range(0, 7)];
      else if (pick < 95) c = 8'($urandom_range(CH_LA, CH_LZ));
      else c = 8'($urandom_range(1, 255));
      send_char(c);
      if ($urandom_range(99) < 40) send_char(CH_HASH);
      if ($urandom_range(99) < 25) send_char(CH_DOT);
      if ($urandom_range(99) < 50) begin
        v = $urandom_range(0, 1) ? $urandom_range(4, 7) : $urandom_range(0, 9);
        send_char(8'(CH_DIG0 + v));
      end
      if ($urandom_range(99) < 5) send_char(8'($urandom_range(1, 255)));
      if (i < n - 1 || $urandom_range(99) < 15) send_char(CH_COMMA);
    end
    send_char(CH_NUL);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    logic ok;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= WNT_ADDR;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!ok);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_whole_note(input logic [WntW-1:0] v);
    logic [31:0] rd;
    drain();
    apb_xfer(1'b1, {8'h00, v}, rd);
    whole_note = v;
    settings_used++;
    apb_xfer(1'b0, '0, rd);
    if (rd !== {8'h00, v}) note_err($sformatf("whole_note_time readback %h, want %h", rd, v));
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    m_axis_tready <= (cyc inside {[3000:5000]}) || ($urandom_range(99) >= 10);
  end

  always @(negedge clk_i) begin
    parse_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[32:8], m_axis_tdata[46:33],
              m_axis_tlast};
      if (due_outputs.size() == 0) begin
        note_err($sformatf("unexpected output kind=%0d title=%02h time=%0d freq=%0d last=%0d",
                           got.kind, got.title, got.note_time, got.freq, got.last));
      end else begin
        want = due_outputs.pop_front();
        if (got.kind !== want.kind || got.title !== want.title ||
            got.note_time !== want.note_time || got.freq !== want.freq ||
            got.last !== want.last) begin
          note_err($sformatf({"exp kind=%0d title=%02h time=%0d freq=%0d last=%0d, ",
                              "got kind=%0d title=%02h time=%0d freq=%0d last=%0d"},
                             want.kind, want.title, want.note_time, want.freq, want.last,
                             got.kind, got.title, got.note_time, got.freq, got.last));
        end
      end
      case (got.kind)
        KIND_TITLE: titles_seen++;
        KIND_NOTE: notes_seen++;
        default: ends_seen++;
      endcase
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d outputs outstanding",
               quiet_cycles, due_outputs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    logic [WntW-1:0] wnt_vals [6];
    int ph;
    wnt_vals = '{24'hFFFFFF, 24'd1, 24'($urandom_range(1, 24'hFFFFFF)), 24'd1000,
                 24'($urandom_range(1, 300)), WNT_RESET};
    whole_note = WNT_RESET;
    song_restart();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_xfer(1'b0, '0, rd);
    if (rd !== {8'h00, WNT_RESET}) note_err($sformatf("whole_note_time after reset %h", rd));

    foreach (dir_tbl[i]) send_char(dir_tbl[i].ch, dir_tbl[i].typed, dir_tbl[i].want);

    for (ph = 0; ph < 6; ph++) begin
      set_whole_note(wnt_vals[ph]);
      while (bytes_sent < 28 + (ph + 1) * 205) write_song();
    end
    drain();

    if (due_outputs.size() != 0) note_err("outputs still outstanding at end of run");
    $display("Run: %0d text bytes (directed table, then random songs, noise and broken text),",
             bytes_sent);
    $display("  %0d whole-note settings; checked %0d title bytes, %0d notes, %0d bare ends.",
             settings_used + 1, titles_seen, notes_seen, ends_seen);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/rtp_pkg.sv
sv/rtp_div.sv
sv/rtp_dpath.sv
sv/rtp_ctrl.sv
sv/ringtone_text_note_parser.sv
verif/testbench.sv
